FILE: hdl/sfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfc_pkg
// Shared types, codes and constants of the header-signature file carver.
// ----------------------------------------------------------------------------
package sfc_pkg;

    localparam int OFFSET_BITS    = 48;
    localparam int LENGTH_BITS    = 24;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 24;

    typedef logic [OFFSET_BITS-1:0]    offset_t;
    typedef logic [LENGTH_BITS-1:0]    length_t;
    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
    typedef logic [CFG_DATA_BITS-1:0]  cfg_data_t;

    localparam logic [1:0] KIND_OFFICE_FOUND   = 2'd0;
    localparam logic [1:0] KIND_COMPOUND_FOUND = 2'd1;
    localparam logic [1:0] KIND_CARVE_END      = 2'd2;

    localparam logic [1:0] CLASS_SHEET    = 2'd0;
    localparam logic [1:0] CLASS_TEXT     = 2'd1;
    localparam logic [1:0] CLASS_OTHER    = 2'd2;
    localparam logic [1:0] CLASS_COMPOUND = 2'd3;

    localparam cfg_index_t CFG_MIN_DISTANCE     = 2'd0;
    localparam cfg_index_t CFG_ZERO_RUN_NEEDED  = 2'd1;
    localparam cfg_index_t CFG_MAX_CARVE_LENGTH = 2'd2;

    localparam logic [15:0] MIN_DISTANCE_RESET     = 16'd4000;
    localparam logic [7:0]  ZERO_RUN_NEEDED_RESET  = 8'd80;
    localparam length_t     MAX_CARVE_LENGTH_RESET = 24'd10485760;

    localparam logic [39:0] OFFICE_SIG   = 40'h504b03040a;
    localparam logic [63:0] COMPOUND_SIG = 64'hd0cf11e0a1b11ae1;

    typedef struct packed {
        logic [1:0] event_kind;
        logic [1:0] file_class;
        offset_t    start_offset;
        length_t    carve_length;
        logic       carved;
        logic       last_of_run;
    } result_t;

endpackage

FILE: hdl/sfc_image_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfc_image_if
// Image byte channel: one raw byte per request with an end-of-image mark.
// ----------------------------------------------------------------------------
interface sfc_image_if import sfc_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_image;

    modport source (output valid, data_byte, end_of_image, input ready);
    modport sink (input valid, data_byte, end_of_image, output ready);
endinterface

FILE: hdl/sfc_event_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfc_event_if
// Event channel: header finds and carve ends, one per request.
// ----------------------------------------------------------------------------
interface sfc_event_if import sfc_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [1:0] event_kind;
    logic [1:0] file_class;
    offset_t    start_offset;
    length_t    carve_length;
    logic       carved;
    logic       last_of_run;

    modport source (output valid, event_kind, file_class, start_offset, carve_length,
                    carved, last_of_run, input ready);
    modport sink (input valid, event_kind, file_class, start_offset, carve_length,
                  carved, last_of_run, output ready);
endinterface

FILE: hdl/sfc_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface sfc_cfg_if import sfc_pkg::*; ();
    logic       valid;
    logic       ready;
    cfg_index_t index;
    cfg_data_t  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/signature_file_carver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signature_file_carver
// Scans a disk image byte by byte for zip-office and compound-document
// headers, reports each find and carve end with offsets and lengths.
// ----------------------------------------------------------------------------
// The block takes one image byte per clock cycle while the image port is
// ready. Header matching, carve tracking and classification for a byte are
// all resolved in the cycle the byte is taken, and its events (at most two)
// are written into a four-entry event queue. The event port drains one
// event per cycle while the sink is ready; the image port holds ready low
// only while the queue has room for fewer than two events.
// Configuration writes are taken at any time and apply to the next byte.
// ----------------------------------------------------------------------------
module signature_file_carver import sfc_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    sfc_image_if.sink   image,
    sfc_event_if.source events,
    sfc_cfg_if.sink     cfg
);

    localparam logic [1:0] CARVE_CONT       = 2'd0;
    localparam logic [1:0] CARVE_END_BEFORE = 2'd1;
    localparam logic [1:0] CARVE_END_WITH   = 2'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = QPTR_BITS + 1;

    localparam offset_t POS_M4_INIT = offset_t'(0) - offset_t'(4);
    localparam offset_t POS_M7_INIT = offset_t'(0) - offset_t'(7);
    localparam offset_t POS_P5_INIT = offset_t'(5);
    localparam offset_t POS_P6_INIT = offset_t'(6);
    localparam length_t OFFICE_REL_INIT   = length_t'(5);
    localparam length_t COMPOUND_REL_INIT = length_t'(8);

    typedef struct packed {
        logic [1:0] res;
        length_t    len;
        logic [7:0] zc;
    } carve_step_t;

    function automatic carve_step_t carve_eval(
        input length_t     rel,
        input logic [7:0]  zc,
        input logic [7:0]  b,
        input logic        eoi,
        input logic [15:0] min_d,
        input logic [7:0]  zrn,
        input length_t     max_len
    );
        logic [7:0]         need;
        logic               ge_min;
        logic [LENGTH_BITS:0] rel_p1;
        carve_step_t        st;
        need   = (zrn == 8'd0) ? 8'd1 : zrn;
        ge_min = rel >= {{(LENGTH_BITS-16){1'b0}}, min_d};
        rel_p1 = {1'b0, rel} + {{LENGTH_BITS{1'b0}}, 1'b1};
        st.res = CARVE_CONT;
        st.len = rel;
        st.zc  = zc;
        if (ge_min && (b != 8'd0) && (zc >= need))
        begin
            st.res = CARVE_END_BEFORE;
        end
        else
        begin
            if (ge_min)
            begin
                if (b == 8'd0)
                begin
                    st.zc = (zc == 8'hff) ? zc : zc + 8'd1;
                end
                else
                begin
                    st.zc = 8'd0;
                end
            end
            if (eoi || (rel_p1 >= {1'b0, max_len}))
            begin
                st.res = CARVE_END_WITH;
                st.len = rel_p1[LENGTH_BITS-1:0];
            end
        end
        return st;
    endfunction

    function automatic logic [7:0] sheet_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h77;
            4'd1:    c = 8'h6f;
            4'd2:    c = 8'h72;
            4'd3:    c = 8'h6b;
            4'd4:    c = 8'h73;
            4'd5:    c = 8'h68;
            4'd6:    c = 8'h65;
            4'd7:    c = 8'h65;
            4'd8:    c = 8'h74;
            4'd9:    c = 8'h73;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] text_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h77;
            3'd1:    c = 8'h6f;
            3'd2:    c = 8'h72;
            3'd3:    c = 8'h64;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    logic [15:0] min_distance_reg;
    logic [7:0]  zero_run_needed_reg;
    length_t     max_carve_length_reg;

    offset_t     pos_reg, pos_next;
    offset_t     pos_m4_reg, pos_m4_next;
    offset_t     pos_m7_reg, pos_m7_next;
    offset_t     pos_p5_reg, pos_p5_next;
    offset_t     pos_p6_reg, pos_p6_next;
    offset_t     resume_reg, resume_next;
    logic [55:0] recent_reg, recent_next;

    logic        office_open_reg, office_open_next;
    offset_t     office_start_reg, office_start_next;
    length_t     office_rel_reg, office_rel_next;
    logic [7:0]  office_zc_reg, office_zc_next;
    logic [3:0]  sheet_prog_reg, sheet_prog_next;
    logic [2:0]  text_prog_reg, text_prog_next;
    logic [1:0]  class_flags_reg, class_flags_next;

    logic        compound_open_reg, compound_open_next;
    offset_t     compound_start_reg, compound_start_next;
    length_t     compound_rel_reg, compound_rel_next;
    logic [7:0]  compound_zc_reg, compound_zc_next;

    result_t                queue_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0]   count_reg, count_next;

    logic        accept;
    logic        pop;
    logic [7:0]  b;
    logic        eoi;
    logic [63:0] window;
    carve_step_t office_st;
    carve_step_t compound_st;
    logic        office_ended;
    logic        compound_ended;
    logic        office_after;
    logic        compound_after;
    logic [3:0]  sheet_step;
    logic [2:0]  text_step;
    logic [1:0]  flags_step;
    logic [1:0]  end_class;
    logic        office_hit;
    logic        compound_hit;
    logic        m4_ge_resume, m4_ge_p5, m4_ge_p6;
    logic        m7_ge_resume, m7_ge_p5, m7_ge_p6;
    logic        office_ok;
    logic        compound_ok;
    logic        office_found;
    logic        compound_found;
    logic        found_carved;
    result_t     office_end_res;
    result_t     compound_end_res;
    result_t     found_res;
    result_t     slot0;
    result_t     slot1;
    logic [1:0]  push_n;

    assign accept = image.valid && image.ready;
    assign pop    = events.valid && events.ready;
    assign b      = image.data_byte;
    assign eoi    = image.end_of_image;
    assign window = {recent_reg, b};

    assign image.ready = count_reg <= QCNT_BITS'(QUEUE_DEPTH - 2);
    assign cfg.ready   = 1'b1;

    assign events.valid        = count_reg != '0;
    assign events.event_kind   = queue_reg[rd_ptr_reg].event_kind;
    assign events.file_class   = queue_reg[rd_ptr_reg].file_class;
    assign events.start_offset = queue_reg[rd_ptr_reg].start_offset;
    assign events.carve_length = queue_reg[rd_ptr_reg].carve_length;
    assign events.carved       = queue_reg[rd_ptr_reg].carved;
    assign events.last_of_run  = queue_reg[rd_ptr_reg].last_of_run;

    assign m4_ge_resume = pos_m4_reg >= resume_reg;
    assign m4_ge_p5     = pos_m4_reg >= pos_p5_reg;
    assign m4_ge_p6     = pos_m4_reg >= pos_p6_reg;
    assign m7_ge_resume = pos_m7_reg >= resume_reg;
    assign m7_ge_p5     = pos_m7_reg >= pos_p5_reg;
    assign m7_ge_p6     = pos_m7_reg >= pos_p6_reg;

    always_comb
    begin
        office_st = carve_eval(office_rel_reg, office_zc_reg, b, eoi, min_distance_reg,
                               zero_run_needed_reg, max_carve_length_reg);
        compound_st = carve_eval(compound_rel_reg, compound_zc_reg, b, eoi, min_distance_reg,
                                 zero_run_needed_reg, max_carve_length_reg);
        office_ended   = office_open_reg && (office_st.res != CARVE_CONT);
        compound_ended = compound_open_reg && (compound_st.res != CARVE_CONT);
        office_after   = office_open_reg && !office_ended;
        compound_after = compound_open_reg && !compound_ended;

        if ((sheet_prog_reg < 4'd10) && (b == sheet_char(sheet_prog_reg)))
        begin
            sheet_step = sheet_prog_reg + 4'd1;
        end
        else
        begin
            sheet_step = (b == sheet_char(4'd0)) ? 4'd1 : 4'd0;
        end
        if ((text_prog_reg < 3'd4) && (b == text_char(text_prog_reg)))
        begin
            text_step = text_prog_reg + 3'd1;
        end
        else
        begin
            text_step = (b == text_char(3'd0)) ? 3'd1 : 3'd0;
        end
        flags_step = class_flags_reg;
        if (sheet_step >= 4'd10)
        begin
            flags_step[0] = 1'b1;
            sheet_step    = 4'd0;
        end
        if (text_step >= 3'd4)
        begin
            flags_step[1] = 1'b1;
            text_step     = 3'd0;
        end
        if (office_st.res == CARVE_END_BEFORE)
        begin
            sheet_step = sheet_prog_reg;
            text_step  = text_prog_reg;
            flags_step = class_flags_reg;
        end

        if (flags_step[0])
        begin
            end_class = CLASS_SHEET;
        end
        else if (flags_step[1])
        begin
            end_class = CLASS_TEXT;
        end
        else
        begin
            end_class = CLASS_OTHER;
        end

        office_hit   = window[39:0] == OFFICE_SIG;
        compound_hit = window == COMPOUND_SIG;
        if (office_ended)
        begin
            office_ok   = (office_st.res == CARVE_END_WITH) ? m4_ge_p6 : m4_ge_p5;
            compound_ok = (office_st.res == CARVE_END_WITH) ? m7_ge_p6 : m7_ge_p5;
        end
        else
        begin
            office_ok   = m4_ge_resume;
            compound_ok = m7_ge_resume;
        end
        office_found   = !office_after && office_hit && office_ok;
        compound_found = !office_after && !office_hit && compound_hit && compound_ok;
        found_carved   = office_found ? !eoi : (!eoi && !compound_after);

        office_end_res.event_kind   = KIND_CARVE_END;
        office_end_res.file_class   = end_class;
        office_end_res.start_offset = office_start_reg;
        office_end_res.carve_length = office_st.len;
        office_end_res.carved       = 1'b0;
        office_end_res.last_of_run  = 1'b0;

        compound_end_res.event_kind   = KIND_CARVE_END;
        compound_end_res.file_class   = CLASS_COMPOUND;
        compound_end_res.start_offset = compound_start_reg;
        compound_end_res.carve_length = compound_st.len;
        compound_end_res.carved       = 1'b0;
        compound_end_res.last_of_run  = 1'b0;

        found_res.event_kind   = office_found ? KIND_OFFICE_FOUND : KIND_COMPOUND_FOUND;
        found_res.file_class   = office_found ? CLASS_OTHER : CLASS_COMPOUND;
        found_res.start_offset = office_found ? pos_m4_reg : pos_m7_reg;
        found_res.carve_length = '0;
        found_res.carved       = found_carved;
        found_res.last_of_run  = 1'b0;

        slot0  = found_res;
        slot1  = found_res;
        push_n = 2'd0;
        if (office_ended)
        begin
            slot0 = office_end_res;
            if (compound_ended)
            begin
                slot1  = compound_end_res;
                push_n = 2'd2;
            end
            else if (office_found || compound_found)
            begin
                push_n = 2'd2;
            end
            else
            begin
                push_n = 2'd1;
            end
        end
        else if (compound_ended)
        begin
            slot0  = compound_end_res;
            push_n = (office_found || compound_found) ? 2'd2 : 2'd1;
        end
        else if (office_found || compound_found)
        begin
            push_n = 2'd1;
        end
        slot0.last_of_run = push_n == 2'd1;
        slot1.last_of_run = 1'b1;
        if (!accept)
        begin
            push_n = 2'd0;
        end
    end

    always_comb
    begin
        pos_next            = pos_reg;
        pos_m4_next         = pos_m4_reg;
        pos_m7_next         = pos_m7_reg;
        pos_p5_next         = pos_p5_reg;
        pos_p6_next         = pos_p6_reg;
        resume_next         = resume_reg;
        recent_next         = recent_reg;
        office_open_next    = office_open_reg;
        office_start_next   = office_start_reg;
        office_rel_next     = office_rel_reg;
        office_zc_next      = office_zc_reg;
        sheet_prog_next     = sheet_prog_reg;
        text_prog_next      = text_prog_reg;
        class_flags_next    = class_flags_reg;
        compound_open_next  = compound_open_reg;
        compound_start_next = compound_start_reg;
        compound_rel_next   = compound_rel_reg;
        compound_zc_next    = compound_zc_reg;

        if (accept)
        begin
            recent_next = window[55:0];
            if (office_open_reg)
            begin
                office_zc_next   = office_st.zc;
                office_rel_next  = office_rel_reg + length_t'(1);
                sheet_prog_next  = sheet_step;
                text_prog_next   = text_step;
                class_flags_next = flags_step;
                if (office_ended)
                begin
                    office_open_next = 1'b0;
                    resume_next = (office_st.res == CARVE_END_WITH) ? pos_p6_reg : pos_p5_reg;
                end
            end
            if (compound_open_reg)
            begin
                compound_zc_next  = compound_st.zc;
                compound_rel_next = compound_rel_reg + length_t'(1);
                if (compound_ended)
                begin
                    compound_open_next = 1'b0;
                end
            end
            if (office_found && found_carved)
            begin
                office_open_next  = 1'b1;
                office_start_next = pos_m4_reg;
                office_rel_next   = OFFICE_REL_INIT;
                office_zc_next    = 8'd0;
                sheet_prog_next   = 4'd0;
                text_prog_next    = 3'd0;
                class_flags_next  = 2'd0;
            end
            if (compound_found && found_carved)
            begin
                compound_open_next  = 1'b1;
                compound_start_next = pos_m7_reg;
                compound_rel_next   = COMPOUND_REL_INIT;
                compound_zc_next    = 8'd0;
            end
            if (eoi)
            begin
                pos_next    = '0;
                pos_m4_next = POS_M4_INIT;
                pos_m7_next = POS_M7_INIT;
                pos_p5_next = POS_P5_INIT;
                pos_p6_next = POS_P6_INIT;
                recent_next = '0;
                resume_next = '0;
            end
            else
            begin
                pos_next    = pos_reg + offset_t'(1);
                pos_m4_next = pos_m4_reg + offset_t'(1);
                pos_m7_next = pos_m7_reg + offset_t'(1);
                pos_p5_next = pos_p5_reg + offset_t'(1);
                pos_p6_next = pos_p6_reg + offset_t'(1);
            end
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_BITS'(push_n);
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_BITS'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_BITS'(push_n) - QCNT_BITS'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_distance_reg     <= MIN_DISTANCE_RESET;
            zero_run_needed_reg  <= ZERO_RUN_NEEDED_RESET;
            max_carve_length_reg <= MAX_CARVE_LENGTH_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_MIN_DISTANCE:     min_distance_reg     <= cfg.data[15:0];
                CFG_ZERO_RUN_NEEDED:  zero_run_needed_reg  <= cfg.data[7:0];
                CFG_MAX_CARVE_LENGTH: max_carve_length_reg <= cfg.data[LENGTH_BITS-1:0];
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg            <= '0;
            pos_m4_reg         <= POS_M4_INIT;
            pos_m7_reg         <= POS_M7_INIT;
            pos_p5_reg         <= POS_P5_INIT;
            pos_p6_reg         <= POS_P6_INIT;
            resume_reg         <= '0;
            recent_reg         <= '0;
            office_open_reg    <= 1'b0;
            office_start_reg   <= '0;
            office_rel_reg     <= '0;
            office_zc_reg      <= '0;
            sheet_prog_reg     <= '0;
            text_prog_reg      <= '0;
            class_flags_reg    <= '0;
            compound_open_reg  <= 1'b0;
            compound_start_reg <= '0;
            compound_rel_reg   <= '0;
            compound_zc_reg    <= '0;
            wr_ptr_reg         <= '0;
            rd_ptr_reg         <= '0;
            count_reg          <= '0;
        end
        else
        begin
            pos_reg            <= pos_next;
            pos_m4_reg         <= pos_m4_next;
            pos_m7_reg         <= pos_m7_next;
            pos_p5_reg         <= pos_p5_next;
            pos_p6_reg         <= pos_p6_next;
            resume_reg         <= resume_next;
            recent_reg         <= recent_next;
            office_open_reg    <= office_open_next;
            office_start_reg   <= office_start_next;
            office_rel_reg     <= office_rel_next;
            office_zc_reg      <= office_zc_next;
            sheet_prog_reg     <= sheet_prog_next;
            text_prog_reg      <= text_prog_next;
            class_flags_reg    <= class_flags_next;
            compound_open_reg  <= compound_open_next;
            compound_start_reg <= compound_start_next;
            compound_rel_reg   <= compound_rel_next;
            compound_zc_reg    <= compound_zc_next;
            wr_ptr_reg         <= wr_ptr_next;
            rd_ptr_reg         <= rd_ptr_next;
            count_reg          <= count_next;
        end
    end

    // hold queued events; write the second slot behind the first
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            queue_reg[wr_ptr_reg] <= slot0;
        end
        if (push_n == 2'd2)
        begin
            queue_reg[wr_ptr_reg + QPTR_BITS'(1)] <= slot1;
        end
    end

endmodule
